// ===== rtl/core/btwf_pkg.sv =====
package btwf_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int LEN_W   = 13;
  localparam int AVG_W   = 13;
  localparam int SDL_W   = 12;
  localparam int START_W = 12;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 2;

  localparam logic [LEN_W-1:0] LEN_RST = 13'd64;
  localparam logic [AVG_W-1:0] AVG_RST = 13'd4095;
  localparam logic [SDL_W-1:0] SDL_RST = 12'd4095;

  typedef enum logic [IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_MAX_AVERAGE   = 2'd1,
    REG_STDEV_LIMIT   = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CHECK,
    B_READ,
    B_DRAIN,
    B_MUL1,
    B_MUL2,
    B_DIFF,
    B_DEC,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/core/btwf_front.sv =====
module btwf_front #(
  parameter int MAX_SAMPLES = btwf_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = btwf_pkg::SAMPLE_BITS_DEF,
  localparam int AW = $clog2(MAX_SAMPLES),
  localparam int CW = AW + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last,
  input  logic                   hold,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [SAMPLE_BITS-1:0] wr_data,
  output logic                   job_push,
  output logic [CW-1:0]          job_n
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          take;
  logic          room;

  assign in_stall = hold;
  assign take     = in_valid && !hold;
  assign room     = count < MAX_CNT;
  assign wr_en    = take && room;
  assign wr_addr  = count[AW-1:0];
  assign wr_data  = sample;

  always_comb begin
    count_next = count;
    if (wr_en) begin
      count_next = count + CW'(1);
    end
  end

  assign job_push = take && last;
  assign job_n    = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (job_push) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/btwf_queue.sv =====
module btwf_queue #(
  parameter int WIDTH = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slot [2];
  logic             rd_ptr;
  logic             wr_ptr;
  logic [1:0]       fill;

  assign not_empty = fill != 2'd0;
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && fill != 2'd2) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && fill != 2'd2) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && fill != 2'd2, pop && not_empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/btwf_back.sv =====
module btwf_back #(
  parameter int MAX_SAMPLES = btwf_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = btwf_pkg::SAMPLE_BITS_DEF,
  localparam int AW = $clog2(MAX_SAMPLES),
  localparam int CW = AW + 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic [SAMPLE_BITS-1:0]          wr_data,
  input  logic                            job_valid,
  input  logic [CW-1:0]                   job_n,
  output logic                            job_pop,
  output logic                            busy,
  input  logic [btwf_pkg::LEN_W-1:0]      window_length,
  input  logic [btwf_pkg::AVG_W-1:0]      max_average,
  input  logic [btwf_pkg::SDL_W-1:0]      stdev_limit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [btwf_pkg::START_W-1:0]    baseline_start
);

  localparam int LW   = btwf_pkg::LEN_W;
  localparam int PW   = ((CW > LW + 1) ? CW : LW + 1) + 1;
  localparam int SW   = SAMPLE_BITS + LW;
  localparam int QW   = 2 * SAMPLE_BITS + LW;
  localparam int DW   = LW + QW;
  localparam int SLW  = btwf_pkg::SDL_W + LW;
  localparam int ABW  = btwf_pkg::AVG_W + LW;
  localparam int CMPW = (DW > 2 * SLW) ? DW : 2 * SLW;

  logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rdata;

  btwf_pkg::back_state_t state;
  btwf_pkg::back_state_t state_next;

  logic [CW-1:0]   n;
  logic [PW-1:0]   s;
  logic [PW-1:0]   ns;
  logic            cur_last;
  logic            nxt_last;
  logic [PW-1:0]   rd_pos;
  logic [LW-1:0]   rd_cnt;
  logic            rd_slot;
  logic            rd_vld;
  logic            rd_slot_d;
  logic [SW-1:0]   sum0;
  logic [SW-1:0]   sum1;
  logic [QW-1:0]   sq0;
  logic [QW-1:0]   sq1;
  logic [DW-1:0]   pa;
  logic [DW-1:0]   pb;
  logic [DW-1:0]   d0;
  logic [DW-1:0]   d1;
  logic [SLW-1:0]  sl;
  logic [CMPW-1:0] sdb;
  logic [ABW-1:0]  avgb;

  logic [PW-1:0]   len_p;
  logic [PW-1:0]   end_p;
  logic [PW-1:0]   end2_p;
  logic [PW-1:0]   n_p;
  logic            out_free;
  logic            issue;
  logic            last_issue;

  logic            cu_avg_ok;
  logic            ne_avg_ok;
  logic            ne_avg_above;
  logic            cu_sd_ok;
  logic            ne_sd_ok;
  logic            fin;
  logic            fin_found;
  logic [PW-1:0]   pick;
  logic            res_found;
  logic [PW-1:0]   res_pick;
  logic            out_found;
  logic [btwf_pkg::START_W-1:0] out_start;

  assign len_p  = PW'(window_length);
  assign n_p    = PW'(n);
  assign end_p  = s + len_p;
  assign end2_p = end_p + len_p;
  assign out_free = !out_valid || !out_stall;
  assign busy = state != btwf_pkg::B_IDLE;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata <= mem[rd_pos[AW-1:0]];
    end
  end

  always_comb begin
    cu_avg_ok    = ABW'(sum0) < avgb;
    ne_avg_ok    = ABW'(sum1) < avgb;
    ne_avg_above = ABW'(sum1) > avgb;
    cu_sd_ok     = CMPW'(d0) < sdb;
    ne_sd_ok     = CMPW'(d1) < sdb;
    fin       = 1'b0;
    fin_found = 1'b0;
    pick      = s;
    if (cur_last) begin
      fin       = 1'b1;
      fin_found = cu_avg_ok && cu_sd_ok;
    end else if (cu_sd_ok) begin
      if (cu_avg_ok && ne_avg_ok) begin
        if (d0 < d1) begin
          fin       = 1'b1;
          fin_found = 1'b1;
        end else if (d0 == d1) begin
          if (sum0 < sum1) begin
            fin       = 1'b1;
            fin_found = 1'b1;
          end
        end else if (nxt_last) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          pick      = ns;
        end
      end else if (ne_avg_above) begin
        if (nxt_last) begin
          fin       = 1'b1;
          fin_found = cu_avg_ok;
        end
      end
    end else if (nxt_last) begin
      fin       = 1'b1;
      fin_found = ne_avg_ok && ne_sd_ok;
      pick      = ns;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      btwf_pkg::B_IDLE: begin
        if (job_valid) state_next = btwf_pkg::B_CHECK;
      end
      btwf_pkg::B_CHECK: begin
        if (window_length == '0 || end_p > n_p) state_next = btwf_pkg::B_DONE;
        else                                     state_next = btwf_pkg::B_READ;
      end
      btwf_pkg::B_READ: begin
        if (last_issue) state_next = btwf_pkg::B_DRAIN;
      end
      btwf_pkg::B_DRAIN: state_next = btwf_pkg::B_MUL1;
      btwf_pkg::B_MUL1:  state_next = btwf_pkg::B_MUL2;
      btwf_pkg::B_MUL2:  state_next = btwf_pkg::B_DIFF;
      btwf_pkg::B_DIFF:  state_next = btwf_pkg::B_DEC;
      btwf_pkg::B_DEC: begin
        if (fin) state_next = btwf_pkg::B_DONE;
        else     state_next = btwf_pkg::B_CHECK;
      end
      btwf_pkg::B_DONE: begin
        if (out_free) state_next = btwf_pkg::B_IDLE;
      end
      default: state_next = btwf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = 1'b0;
    issue      = 1'b0;
    last_issue = 1'b0;
    case (state)
      btwf_pkg::B_IDLE: job_pop = job_valid;
      btwf_pkg::B_READ: begin
        issue      = 1'b1;
        last_issue = rd_slot && rd_cnt == LW'(1);
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btwf_pkg::B_IDLE;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      res_found <= 1'b0;
      out_found <= 1'b0;
      out_start <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (state == btwf_pkg::B_IDLE && job_valid) begin
        res_found <= 1'b0;
      end
      if (state == btwf_pkg::B_DEC && fin) begin
        res_found <= fin_found;
      end
      if (state == btwf_pkg::B_DONE && out_free) begin
        out_valid <= 1'b1;
        out_found <= res_found;
        out_start <= res_found ? res_pick[btwf_pkg::START_W-1:0] : '0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_d <= rd_slot;
    case (state)
      btwf_pkg::B_IDLE: begin
        n <= job_n;
        s <= '0;
      end
      btwf_pkg::B_CHECK: begin
        cur_last <= end_p == n_p;
        if (end2_p > n_p) begin
          ns       <= n_p - len_p;
          nxt_last <= 1'b1;
        end else begin
          ns       <= end_p;
          nxt_last <= end2_p == n_p;
        end
        rd_pos  <= s;
        rd_cnt  <= window_length[LW-1:0];
        rd_slot <= 1'b0;
        sum0    <= '0;
        sum1    <= '0;
        sq0     <= '0;
        sq1     <= '0;
      end
      btwf_pkg::B_READ: begin
        if (rd_cnt == LW'(1) && !rd_slot) begin
          rd_pos  <= ns;
          rd_cnt  <= window_length[LW-1:0];
          rd_slot <= 1'b1;
        end else begin
          rd_pos <= rd_pos + PW'(1);
          rd_cnt <= rd_cnt - LW'(1);
        end
      end
      btwf_pkg::B_MUL1: begin
        pa   <= DW'(window_length) * DW'(sq0);
        pb   <= DW'(sum0) * DW'(sum0);
        sl   <= SLW'(stdev_limit) * SLW'(window_length);
        avgb <= ABW'(max_average) * ABW'(window_length);
      end
      btwf_pkg::B_MUL2: begin
        d0  <= pa - pb;
        pa  <= DW'(window_length) * DW'(sq1);
        pb  <= DW'(sum1) * DW'(sum1);
        sdb <= CMPW'(sl) * CMPW'(sl);
      end
      btwf_pkg::B_DIFF: begin
        d1 <= pa - pb;
      end
      btwf_pkg::B_DEC: begin
        s        <= end_p;
        res_pick <= pick;
      end
      default: begin
        rd_pos <= rd_pos;
      end
    endcase
    if (rd_vld) begin
      if (rd_slot_d) begin
        sum1 <= sum1 + SW'(rdata);
        sq1  <= sq1 + QW'(rdata) * QW'(rdata);
      end else begin
        sum0 <= sum0 + SW'(rdata);
        sq0  <= sq0 + QW'(rdata) * QW'(rdata);
      end
    end
  end

  assign found          = out_found;
  assign baseline_start = out_start;

endmodule

// ===== rtl/core/trace_baseline_window_finder.sv =====
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall   sample, last
// out       output     out_valid/out_stall found, baseline_start
// config    input      write_enable       reg_index, write_data
//
// Samples load one per cycle while in_stall is low; a last flag ends the trace
// and starts evaluation. Evaluation rereads the trace memory through its single
// read port: each window step reads the current window and then the next one.
// The input stalls from the last sample until the result is in the output register.
// rst is synchronous; it clears control state and loads the register defaults.
module trace_baseline_window_finder #(
  parameter int MAX_SAMPLES = btwf_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = btwf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          sample,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [btwf_pkg::START_W-1:0]    baseline_start,
  input  logic                            write_enable,
  input  logic [btwf_pkg::IDX_W-1:0]      reg_index,
  input  logic [btwf_pkg::CFG_W-1:0]      write_data
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = AW + 1;

  logic [btwf_pkg::LEN_W-1:0] window_length;
  logic [btwf_pkg::AVG_W-1:0] max_average;
  logic [btwf_pkg::SDL_W-1:0] stdev_limit;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic                   job_push;
  logic [CW-1:0]          job_n;
  logic                   job_pop;
  logic                   job_valid;
  logic [CW-1:0]          job_head;
  logic                   back_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= btwf_pkg::LEN_RST;
      max_average   <= btwf_pkg::AVG_RST;
      stdev_limit   <= btwf_pkg::SDL_RST;
    end else if (write_enable) begin
      case (reg_index)
        btwf_pkg::REG_WINDOW_LENGTH: window_length <= write_data[btwf_pkg::LEN_W-1:0];
        btwf_pkg::REG_MAX_AVERAGE:   max_average   <= write_data[btwf_pkg::AVG_W-1:0];
        btwf_pkg::REG_STDEV_LIMIT:   stdev_limit   <= write_data[btwf_pkg::SDL_W-1:0];
        default:                     stdev_limit   <= stdev_limit;
      endcase
    end
  end

  btwf_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .last     (last),
    .hold     (back_busy || job_valid),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job_push (job_push),
    .job_n    (job_n)
  );

  btwf_queue #(
    .WIDTH(CW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_n),
    .pop       (job_pop),
    .not_empty (job_valid),
    .head      (job_head)
  );

  btwf_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .job_valid      (job_valid),
    .job_n          (job_head),
    .job_pop        (job_pop),
    .busy           (back_busy),
    .window_length  (window_length),
    .max_average    (max_average),
    .stdev_limit    (stdev_limit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .baseline_start (baseline_start)
  );

endmodule
